### hdl/radius_weighted_average_query_top_macros.svh
// assertion helpers for the radius weighted average block
`ifndef RADIUS_WEIGHTED_AVERAGE_QUERY_TOP_MACROS_SVH
`define RADIUS_WEIGHTED_AVERAGE_QUERY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RWA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define RWA_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define RWA_ASSERT(label, clk, rst, prop)
`define RWA_ASSERT_RST(label, clk, prop)
`endif
`endif

### hdl/rwa_pkg.sv
`default_nettype none
package rwa_pkg;
  localparam int unsigned MaxElementsDefault = 1024;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_STORE = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_INSIDE  = 2'd0,
    ST_NEAREST = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_ZEROVOL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_SQR, S_SCAN, S_DX, S_DY, S_DZ, S_ACC, S_DECIDE, S_BEST,
    S_DIV, S_DONE
  } state_t;

  // start and result of the divider
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

### hdl/rwa_div.sv
`default_nettype none
`include "radius_weighted_average_query_top_macros.svh"
// restoring divider, one quotient bit per cycle: q = (num << 16) / den
module rwa_div import rwa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [6:0]  cnt;
  logic        busy;
  logic        neg;
  logic [79:0] num;
  logic [63:0] den;
  logic [64:0] rem;
  logic [79:0] quo;
  logic [64:0] trial;
  logic [64:0] shifted;
  logic        done;
  logic [31:0] quot;

  assign shifted = {rem[63:0], num[79]};
  assign trial   = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 7'd80;
        num <= {req.num, 16'd0};
        den <= req.den;
        neg <= req.neg;
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        num <= {num[78:0], 1'b0};
        if (!trial[64]) begin
          rem <= trial;
          quo <= {quo[78:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[78:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate the final quotient
  always_comb begin
    if (neg) begin
      if (quo[79:31] != '0) quot = 32'h8000_0000;
      else quot = 32'd0 - quo[31:0];
    end else begin
      if (quo[79:31] != '0) quot = 32'h7FFF_FFFF;
      else quot = quo[31:0];
    end
  end

  assign rsp = {done, quot};

  `RWA_ASSERT(a_no_restart, clk, rst, busy && cnt > 7'd1 |-> !req.start)
  `RWA_ASSERT_RST(a_done_idle, clk, done |-> !busy)
  `RWA_ASSERT(a_cnt_range, clk, rst, busy |-> cnt != 7'd0)
endmodule
`default_nettype wire

### hdl/radius_weighted_average_query_top.sv
`default_nettype none
// Table of up to MAX_ELEMENTS mesh elements (centroid, integral, volume) with a
// radius-limited weighted average query, one transaction in flight at a time.
// After reset the valid bits are swept clear one per cycle, and s_axis_tready
// stays low until the sweep is done. Store and unused actions go straight to
// the result; clear sweeps every valid bit first. A query squares the radius,
// walks every slot with one shared 32x32 multiplier (skipping an invalid slot,
// taking the three axis differences and the accumulate step for a valid one),
// decides, falls back to the nearest entry if no volume lies inside, runs the
// 80-step restoring divider when there is a volume to divide by and presents
// the result. Input is not ready again until the result transaction is taken.
// s_axis_tuser carries the action, m_axis_tuser the status.
module radius_weighted_average_query_top import rwa_pkg::*; #(
  parameter int unsigned MAX_ELEMENTS = MaxElementsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // elem_index[9:0], pos_x[41:10], pos_y[73:42], pos_z[105:74],
  // integral_in[153:106], volume_in[185:154], radius[217:186]
  input  wire logic [223:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // average[31:0]
  output logic [31:0]       m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser
);
  localparam int unsigned IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  logic valid_bits [MAX_ELEMENTS];
  logic [95:0] cmem [MAX_ELEMENTS];
  logic [79:0] ivmem [MAX_ELEMENTS];
  logic [95:0] crd;
  logic [79:0] ivrd;
  logic        vrd;

  state_t state, state_next;
  logic [IW:0] idx;
  logic [IW:0] vaddr;
  logic [IW-1:0] waddr;
  logic        store_hit;
  logic        vwe;
  logic [IW-1:0] vwaddr;
  logic        vwdata;
  logic signed [31:0] px, py, pz;
  logic [31:0] rad;
  logic [63:0] r2;
  logic [65:0] d2;
  logic [63:0] isum, vsum;
  logic        found;
  logic [65:0] bestd;
  logic [79:0] bestiv;
  logic [31:0] avg;
  status_t     stat;
  div_req_t    dreq;
  div_rsp_t    drsp;

  // shared multiplier: operand muxed by state
  logic [31:0] mop_a;
  logic [31:0] mop_b;
  logic [63:0] prod;
  logic [32:0] diff;

  always_comb begin
    unique case (state)
      S_DX: diff = {px[31], px} - {crd[31], crd[31:0]};
      S_DY: diff = {py[31], py} - {crd[63], crd[63:32]};
      default: diff = {pz[31], pz} - {crd[95], crd[95:64]};
    endcase
    mop_a = diff[32] ? 32'(33'd0 - diff) : diff[31:0];
    if (state == S_SQR) mop_a = rad;
    mop_b = mop_a;
    prod = mop_a * mop_b;
  end

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  assign waddr = IW'(s_axis_tdata[9:0]);
  assign store_hit = (state == S_IDLE) && s_axis_tvalid && s_axis_tready
                     && action_t'(s_axis_tuser) == ACT_STORE
                     && {22'd0, s_axis_tdata[9:0]} < MAX_ELEMENTS;

  // valid bit writes: sweep after reset and on clear, set on store
  always_comb begin
    vwe = 1'b0;
    vwaddr = idx[IW-1:0];
    vwdata = 1'b0;
    if (!rst && (state == S_INIT || state == S_CLEAR)) begin
      vwe = 1'b1;
    end else if (!rst && store_hit) begin
      vwe = 1'b1;
      vwaddr = waddr;
      vwdata = 1'b1;
    end
  end

  // valid bit read address is the scan index's next value, so vrd matches the new idx
  always_comb begin
    vaddr = idx;
    if (state == S_ACC
        || (state == S_SCAN && idx != (IW+1)'(MAX_ELEMENTS) && !vrd))
      vaddr = idx + {{IW{1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (store_hit) begin
      cmem[waddr] <= s_axis_tdata[105:10];
      ivmem[waddr] <= s_axis_tdata[185:106];
    end
    if (vwe) valid_bits[vwaddr] <= vwdata;
    crd  <= cmem[idx[IW-1:0]];
    ivrd <= ivmem[idx[IW-1:0]];
    vrd  <= valid_bits[vaddr[IW-1:0]];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:   if (idx == (IW+1)'(MAX_ELEMENTS - 1)) state_next = S_IDLE;
      S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        unique case (action_t'(s_axis_tuser))
          ACT_CLEAR: state_next = S_CLEAR;
          ACT_QUERY: state_next = S_SQR;
          default:   state_next = S_DONE;
        endcase
      end
      S_CLEAR:  if (idx == (IW+1)'(MAX_ELEMENTS - 1)) state_next = S_DONE;
      S_SQR:    state_next = S_SCAN;
      S_SCAN:   if (idx == (IW+1)'(MAX_ELEMENTS)) state_next = S_DECIDE;
                else if (vrd) state_next = S_DX;
                else state_next = S_SCAN;
      S_DX:     state_next = S_DY;
      S_DY:     state_next = S_DZ;
      S_DZ:     state_next = S_ACC;
      S_ACC:    state_next = S_SCAN;
      S_DECIDE: begin
        if (!found || vsum != '0) state_next = (found ? S_DIV : S_DONE);
        else state_next = S_BEST;
      end
      S_BEST:   state_next = (bestiv[79:48] == '0) ? S_DONE : S_DIV;
      S_DIV:    if (drsp.done) state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx <= '0;
      m_axis_tvalid <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      state <= state_next;
      dreq.start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          px <= s_axis_tdata[41:10];
          py <= s_axis_tdata[73:42];
          pz <= s_axis_tdata[105:74];
          rad <= s_axis_tdata[217:186];
          idx <= '0;
          isum <= '0;
          vsum <= '0;
          found <= 1'b0;
          avg <= '0;
          stat <= ST_INSIDE;
        end
        S_INIT, S_CLEAR: idx <= idx + {{IW{1'b0}}, 1'b1};
        S_SQR: r2 <= prod;
        S_SCAN: if (idx != (IW+1)'(MAX_ELEMENTS) && !vrd)
          idx <= idx + {{IW{1'b0}}, 1'b1};
        S_DX: d2 <= {2'd0, prod};
        S_DY: d2 <= d2 + {2'd0, prod};
        S_DZ: d2 <= d2 + {2'd0, prod};
        S_ACC: begin
          if (!found || d2 < bestd) begin
            found <= 1'b1;
            bestd <= d2;
            bestiv <= ivrd;
          end
          if (d2 < {2'd0, r2}) begin
            isum <= isum + {{16{ivrd[47]}}, ivrd[47:0]};
            vsum <= vsum + {32'd0, ivrd[79:48]};
          end
          idx <= idx + {{IW{1'b0}}, 1'b1};
        end
        S_DECIDE: begin
          if (!found) stat <= ST_EMPTY;
          else if (vsum != '0) begin
            dreq.start <= 1'b1;
            dreq.neg <= isum[63];
            dreq.num <= isum[63] ? 64'd0 - isum : isum;
            dreq.den <= vsum;
          end
        end
        S_BEST: begin
          if (bestiv[79:48] == '0) stat <= ST_ZEROVOL;
          else begin
            stat <= ST_NEAREST;
            dreq.start <= 1'b1;
            dreq.neg <= bestiv[47];
            dreq.num <= bestiv[47] ? 64'd0 - {{16{bestiv[47]}}, bestiv[47:0]}
                                   : {16'd0, bestiv[47:0]};
            dreq.den <= {32'd0, bestiv[79:48]};
          end
        end
        S_DIV: if (drsp.done) avg <= drsp.quot;
        S_DONE: m_axis_tvalid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = avg;
  assign m_axis_tuser = stat;

  rwa_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));
endmodule
`default_nettype wire
